[design/fdt_pkg.sv]
// Shared widths and constants for the fan duty controller.
// Used by the top level, the bound checker and the testbench.
package fdt_pkg;

    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ADC_W      = 16;
    localparam int SPAN_W     = 16;
    localparam int EIGHTH_W   = 11;
    localparam int TDVD_W     = SPAN_W - 3;
    localparam int PMUL_W     = 8;

    localparam logic [DUTY_W-1:0] HOLD_CODE = DUTY_W'(1);

    localparam logic [ADC_W-1:0] CUR_OFF_LIMIT  = ADC_W'(4500 / 3);
    localparam logic [ADC_W-1:0] CUR_HOLD_LIMIT = ADC_W'(4800 / 3);

    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFF   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LOW  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_HIGH = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_OFF  = CFG_IDX_W'(7);

    localparam logic [DUTY_W-1:0]        RST_DUTY_MIN   = 8'd7;
    localparam logic [DUTY_W-1:0]        RST_DUTY_MAX   = 8'd70;
    localparam logic signed [DUTY_W-1:0] RST_TEMP_LOW   = 8'sd45;
    localparam logic signed [DUTY_W-1:0] RST_TEMP_HIGH  = 8'sd60;
    localparam logic signed [DUTY_W-1:0] RST_TEMP_OFF   = 8'sd40;
    localparam logic [DUTY_W-1:0]        RST_POWER_LOW  = 8'd100;
    localparam logic [DUTY_W-1:0]        RST_POWER_HIGH = 8'd255;
    localparam logic [DUTY_W-1:0]        RST_POWER_OFF  = 8'd85;

endpackage

[design/fan_duty_from_temp_current_power.sv]
// An accepted request runs to its result before the next request is taken. The
// power path is the longer one: serial power product, serial scale product, then
// the divider.
// A result waiting on o_out_valid holds off only the final load.
// Synchronous active-low reset: config registers to defaults, duty to zero, idle.
module fan_duty_from_temp_current_power
    import fdt_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [ADC_W-1:0]     i_board_temp,
    input  logic [ADC_W-1:0]            i_current_avg,
    input  logic [ADC_W-1:0]            i_voltage_avg,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [DUTY_W-1:0]           o_fan_duty,
    output logic                        o_duty_updated
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} t_state;

    t_state r_state;

    // configuration
    logic [DUTY_W-1:0]        r_duty_min, r_duty_max;
    logic signed [DUTY_W-1:0] r_temp_low, r_temp_high, r_temp_off;
    logic [DUTY_W-1:0]        r_power_low, r_power_high, r_power_off;

    // per-request context
    logic signed [DUTY_W-1:0] r_deg;
    logic [ADC_W-1:0]         r_cur;
    logic                     r_tq_ok, r_pq_ok;

    logic [DUTY_W-1:0] r_duty;
    logic              r_upd;
    logic              r_out_valid;

    logic                in_acc;
    logic [SPAN_W-1:0]   span;
    logic [EIGHTH_W-1:0] t_x;

    logic                w_done, tm_done, pm_done, td_done, pd_done;
    logic [PMUL_W-1:0]   w_prod;
    logic [SPAN_W-1:0]   t_prod, p_prod;
    logic [TDVD_W-1:0]   t_quot;
    logic [SPAN_W-1:0]   p_quot;
    logic [DUTY_W-1:0]   p_x, t_dvs, p_dvs;

    logic [DUTY_W-1:0] req_t, req_c, req_p, best;
    logic              upd;
    logic              out_free;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        span  = {{(SPAN_W-DUTY_W){1'b0}}, r_duty_max} - {{(SPAN_W-DUTY_W){1'b0}}, r_duty_min};
        // eighths of a degree above the interpolation start
        t_x   = i_board_temp[ADC_W-1:ADC_W-EIGHTH_W] - {r_temp_low, 3'b000};
        p_x   = w_prod - r_power_low;
        t_dvs = DUTY_W'(r_temp_high - r_temp_low);
        p_dvs = r_power_high - r_power_low;
    end

    fdt_mul #(.MCAND_W(PMUL_W), .MPLR_W(PMUL_W)) u_wmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_mcand (i_voltage_avg[ADC_W-1:ADC_W-PMUL_W]),
        .i_mplr  (i_current_avg[ADC_W-1:ADC_W-PMUL_W]),
        .o_done  (w_done),
        .o_prod  (w_prod)
    );

    fdt_mul #(.MCAND_W(SPAN_W), .MPLR_W(EIGHTH_W)) u_tmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_mcand (span),
        .i_mplr  (t_x),
        .o_done  (tm_done),
        .o_prod  (t_prod)
    );

    fdt_mul #(.MCAND_W(SPAN_W), .MPLR_W(DUTY_W)) u_pmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_done),
        .i_mcand (span),
        .i_mplr  (p_x),
        .o_done  (pm_done),
        .o_prod  (p_prod)
    );

    fdt_div #(.DVD_W(TDVD_W), .DVS_W(DUTY_W)) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (tm_done),
        .i_dvd   (t_prod[SPAN_W-1:3]),
        .i_dvs   (t_dvs),
        .o_done  (td_done),
        .o_quot  (t_quot)
    );

    fdt_div #(.DVD_W(SPAN_W), .DVS_W(DUTY_W)) u_pdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (pm_done),
        .i_dvd   (p_prod),
        .i_dvs   (p_dvs),
        .o_done  (pd_done),
        .o_quot  (p_quot)
    );

    always_comb begin
        if (r_deg < r_temp_off) begin
            req_t = '0;
        end else if (r_deg < r_temp_low) begin
            req_t = HOLD_CODE;
        end else if (r_deg >= r_temp_high) begin
            req_t = r_duty_max;
        end else begin
            req_t = t_quot[DUTY_W-1:0] + r_duty_min;
        end

        if (r_cur < CUR_OFF_LIMIT) begin
            req_c = '0;
        end else if (r_cur < CUR_HOLD_LIMIT) begin
            req_c = HOLD_CODE;
        end else begin
            req_c = r_duty_min;
        end

        if (w_prod < r_power_off || w_prod < r_power_low) begin
            req_p = '0;
        end else if (w_prod >= r_power_high) begin
            req_p = r_duty_max;
        end else begin
            req_p = p_quot[DUTY_W-1:0] + r_duty_min;
        end

        best = (req_c > req_t) ? req_c : req_t;
        if (req_p > best) begin
            best = req_p;
        end
        upd = (best != HOLD_CODE);
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_duty      <= '0;
            r_upd       <= 1'b0;
            r_tq_ok     <= 1'b0;
            r_pq_ok     <= 1'b0;
        end else begin
            // drop a taken result; S_DONE reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_tq_ok <= 1'b0;
                        r_pq_ok <= 1'b0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (td_done) begin
                        r_tq_ok <= 1'b1;
                    end
                    if (pd_done) begin
                        r_pq_ok <= 1'b1;
                    end
                    if ((r_tq_ok || td_done) && (r_pq_ok || pd_done)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // load only once the previous result has left
                    if (out_free) begin
                        if (upd) begin
                            r_duty <= best;
                        end
                        r_upd       <= upd;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_deg <= i_board_temp[ADC_W-1:ADC_W-DUTY_W];
            r_cur <= i_current_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_min   <= RST_DUTY_MIN;
            r_duty_max   <= RST_DUTY_MAX;
            r_temp_low   <= RST_TEMP_LOW;
            r_temp_high  <= RST_TEMP_HIGH;
            r_temp_off   <= RST_TEMP_OFF;
            r_power_low  <= RST_POWER_LOW;
            r_power_high <= RST_POWER_HIGH;
            r_power_off  <= RST_POWER_OFF;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_DUTY_MIN:   r_duty_min   <= i_cfg_wdata;
                CFG_DUTY_MAX:   r_duty_max   <= i_cfg_wdata;
                CFG_TEMP_LOW:   r_temp_low   <= i_cfg_wdata;
                CFG_TEMP_HIGH:  r_temp_high  <= i_cfg_wdata;
                CFG_TEMP_OFF:   r_temp_off   <= i_cfg_wdata;
                CFG_POWER_LOW:  r_power_low  <= i_cfg_wdata;
                CFG_POWER_HIGH: r_power_high <= i_cfg_wdata;
                CFG_POWER_OFF:  r_power_off  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fan_duty     = r_duty;
    assign o_duty_updated = r_upd;

endmodule

[design/fdt_mul.sv]
// Bit-serial shift-add multiplier, product kept modulo 2^MCAND_W.
// One multiplier bit per cycle; no package dependency.
module fdt_mul #(
    parameter int MCAND_W = 16,
    parameter int MPLR_W  = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [MCAND_W-1:0] i_mcand,
    input  logic [MPLR_W-1:0]  i_mplr,
    output logic               o_done,
    output logic [MCAND_W-1:0] o_prod
);

    localparam int CNT_W = $clog2(MPLR_W + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [MCAND_W-1:0] r_mcand;
    logic [MPLR_W-1:0]  r_mplr;
    logic [MCAND_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MPLR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= '0;
            r_mcand <= i_mcand;
            r_mplr  <= i_mplr;
        end else if (r_busy) begin
            if (r_mplr[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= {r_mcand[MCAND_W-2:0], 1'b0};
            r_mplr  <= {1'b0, r_mplr[MPLR_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[design/fdt_div.sv]
// Restoring divider, one quotient bit per cycle.
// Quotient shifts into the dividend register; no package dependency.
module fdt_div #(
    parameter int DVD_W = 16,
    parameter int DVS_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   trial;
    logic             q_bit;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        q_bit = (trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_rem <= '0;
        end else if (r_busy) begin
            // subtract when the trial remainder covers the divisor
            if (q_bit) begin
                r_rem <= DVS_W'(trial - {1'b0, r_dvs});
            end else begin
                r_rem <= trial[DVS_W-1:0];
            end
            r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

[design/fdt_chk.sv]
// Port-level checker for the fan duty controller, bound to the top level.
// Depends on fdt_pkg for widths and the hold code.
module fdt_chk
    import fdt_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [DUTY_W-1:0]       o_fan_duty,
    input logic                    o_duty_updated
);

    // reset leaves the block idle with the fan off
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall && (o_fan_duty == '0))
        else $error("block not idle after reset");

    // a taken request closes the input until its work is done
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after a request");

    // duty only moves together with an updated result
    a_duty_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_fan_duty) |-> o_out_valid && o_duty_updated)
        else $error("duty changed without an update");

    // the hold code is never written as a duty
    a_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_duty_updated) |-> (o_fan_duty != HOLD_CODE))
        else $error("hold code loaded as duty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_fan_duty) && $stable(o_duty_updated))
        else $error("stalled result changed");

endmodule

bind fan_duty_from_temp_current_power fdt_chk u_fdt_chk (.*);

[tb/sv/fan_duty_checker.sv]
// Result checker for the fan duty controller: watches the config port and both
// channels, predicts each tick's duty and compares it with the block's output.
// Depends on fdt_pkg for widths, register indexes, limits and reset values.
module fan_duty_checker
    import fdt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [ADC_W-1:0] i_board_temp,
    input  logic [ADC_W-1:0]        i_current_avg,
    input  logic [ADC_W-1:0]        i_voltage_avg,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [DUTY_W-1:0]       i_fan_duty,
    input  logic                    i_duty_updated,
    output int                      o_pending,
    output int                      o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DUTY_W-1:0] fan_duty;
        logic              duty_updated;
    } t_duty_result;

    logic [DUTY_W-1:0]        duty_min, duty_max, power_low, power_high, power_off;
    logic signed [DUTY_W-1:0] temp_low, temp_high, temp_off;
    logic [DUTY_W-1:0]        duty_now;
    t_duty_result             duty_q[$];
    int                       err_cnt = 0;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    function automatic logic [DUTY_W-1:0] temp_demand(logic signed [ADC_W-1:0] temp,
                                                      logic [SPAN_W-1:0] span);
        logic signed [DUTY_W-1:0]   deg;
        logic signed [EIGHTH_W-1:0] eighths;
        logic [SPAN_W-1:0]          offset, scaled, divisor, quot;
        logic [2*SPAN_W-1:0]        prod;
        deg     = temp[ADC_W-1:8];
        eighths = temp[ADC_W-1:5];
        if (deg < temp_off) return '0;
        if (deg < temp_low) return HOLD_CODE;
        if (deg >= temp_high) return duty_max;
        offset  = SPAN_W'(int'(eighths) - int'(temp_low) * 8);
        prod    = span * offset;
        scaled  = prod[SPAN_W-1:0] >> 3;
        divisor = SPAN_W'(int'(temp_high) - int'(temp_low));
        quot    = scaled / divisor;
        return quot[DUTY_W-1:0] + duty_min;
    endfunction

    function automatic logic [DUTY_W-1:0] current_demand(logic [ADC_W-1:0] cur);
        if (cur < CUR_OFF_LIMIT) return '0;
        if (cur < CUR_HOLD_LIMIT) return HOLD_CODE;
        return duty_min;
    endfunction

    function automatic logic [DUTY_W-1:0] power_demand(logic [ADC_W-1:0] volt,
                                                       logic [ADC_W-1:0] cur,
                                                       logic [SPAN_W-1:0] span);
        logic [2*PMUL_W-1:0] watts_full;
        logic [PMUL_W-1:0]   watts;
        logic [SPAN_W-1:0]   above, divisor, quot;
        logic [2*SPAN_W-1:0] prod;
        watts_full = volt[ADC_W-1:8] * cur[ADC_W-1:8];
        watts      = watts_full[PMUL_W-1:0];
        if (watts < power_off) return '0;
        if (watts < power_low) return '0;
        if (watts >= power_high) return duty_max;
        above   = SPAN_W'(watts) - SPAN_W'(power_low);
        prod    = span * above;
        divisor = SPAN_W'(power_high) - SPAN_W'(power_low);
        quot    = prod[SPAN_W-1:0] / divisor;
        return quot[DUTY_W-1:0] + duty_min;
    endfunction

    function automatic t_duty_result next_duty(logic signed [ADC_W-1:0] temp,
                                               logic [ADC_W-1:0] cur,
                                               logic [ADC_W-1:0] volt);
        logic [SPAN_W-1:0] span;
        logic [DUTY_W-1:0] best, other;
        t_duty_result      r;
        span  = SPAN_W'(duty_max) - SPAN_W'(duty_min);
        best  = temp_demand(temp, span);
        other = current_demand(cur);
        if (other > best) best = other;
        other = power_demand(volt, cur, span);
        if (other > best) best = other;
        r.duty_updated = (best != HOLD_CODE);
        r.fan_duty     = r.duty_updated ? best : duty_now;
        return r;
    endfunction

    task automatic note_mismatch(string what);
        err_cnt++;
        if (err_cnt <= 10) $display("%0t: duty mismatch: %s", $realtime, what);
    endtask

    always @(posedge i_clk) begin
        t_duty_result got, want;
        if (!i_rst_n) begin
            duty_min   = RST_DUTY_MIN;
            duty_max   = RST_DUTY_MAX;
            temp_low   = RST_TEMP_LOW;
            temp_high  = RST_TEMP_HIGH;
            temp_off   = RST_TEMP_OFF;
            power_low  = RST_POWER_LOW;
            power_high = RST_POWER_HIGH;
            power_off  = RST_POWER_OFF;
            duty_now   = '0;
            duty_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_DUTY_MIN:   duty_min   = i_cfg_wdata;
                    CFG_DUTY_MAX:   duty_max   = i_cfg_wdata;
                    CFG_TEMP_LOW:   temp_low   = i_cfg_wdata;
                    CFG_TEMP_HIGH:  temp_high  = i_cfg_wdata;
                    CFG_TEMP_OFF:   temp_off   = i_cfg_wdata;
                    CFG_POWER_LOW:  power_low  = i_cfg_wdata;
                    CFG_POWER_HIGH: power_high = i_cfg_wdata;
                    CFG_POWER_OFF:  power_off  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                want     = next_duty(i_board_temp, i_current_avg, i_voltage_avg);
                duty_now = want.fan_duty;
                duty_q.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got.fan_duty     = i_fan_duty;
                got.duty_updated = i_duty_updated;
                if (duty_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected result duty %0d updated %0b",
                                            got.fan_duty, got.duty_updated));
                end else begin
                    want = duty_q.pop_front();
                    if (got.fan_duty !== want.fan_duty
                            || got.duty_updated !== want.duty_updated) begin
                        note_mismatch($sformatf("duty exp %0d got %0d, updated exp %0b got %0b",
                                                want.fan_duty, got.fan_duty,
                                                want.duty_updated, got.duty_updated));
                    end
                end
            end
        end
        o_pending <= duty_q.size();
        o_errors  <= err_cnt;
    end

endmodule

[tb/sv/fan_duty_from_temp_current_power_test.sv]
// Top of the fan duty controller bench: drives config writes and sensor requests
// with random gaps and output stalls; the checker does prediction and comparison.
// Depends on fdt_pkg, fan_duty_checker and the block under test.
module fan_duty_from_temp_current_power_test
    import fdt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 160;
    localparam int NUM_PHASES      = 11;
    localparam int IDLE_LIMIT      = 2000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [ADC_W-1:0] i_board_temp = '0;
    logic [ADC_W-1:0]        i_current_avg = '0;
    logic [ADC_W-1:0]        i_voltage_avg = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [DUTY_W-1:0]       o_fan_duty;
    logic                    o_duty_updated;
    int                      pending, errors;

    // Thresholds now in force, used only to aim the random requests.
    int cfg_temp_low  = int'(RST_TEMP_LOW);
    int cfg_temp_high = int'(RST_TEMP_HIGH);
    int cfg_temp_off  = int'(RST_TEMP_OFF);
    int cfg_power_low  = int'(RST_POWER_LOW);
    int cfg_power_high = int'(RST_POWER_HIGH);
    int cfg_power_off  = int'(RST_POWER_OFF);
    int burst_left = 0;

    fan_duty_from_temp_current_power u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_board_temp   (i_board_temp),
        .i_current_avg  (i_current_avg),
        .i_voltage_avg  (i_voltage_avg),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_fan_duty     (o_fan_duty),
        .o_duty_updated (o_duty_updated)
    );

    fan_duty_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_board_temp   (i_board_temp),
        .i_current_avg  (i_current_avg),
        .i_voltage_avg  (i_voltage_avg),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_fan_duty     (o_fan_duty),
        .i_duty_updated (o_duty_updated),
        .o_pending      (pending),
        .o_errors       (errors)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Receiver: stretches of no stall, random stall, heavy stall and toggling.
    initial begin
        int mode, stretch;
        forever begin
            mode    = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
                @(posedge i_clk);
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= 1'($urandom_range(0, 1));
                    2: i_out_stall <= ($urandom_range(0, 9) < 8);
                    default: i_out_stall <= ~i_out_stall;
                endcase
            end
        end
    end

    // Abort if neither a request, a result nor a config write moves for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en
                    || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Send one request; open a new burst after a random gap when the last one ran out.
    task automatic send_request(logic [ADC_W-1:0] temp, logic [ADC_W-1:0] cur,
                                logic [ADC_W-1:0] volt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        i_in_valid    <= 1'b1;
        i_board_temp  <= temp;
        i_current_avg <= cur;
        i_voltage_avg <= volt;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Drop valid and hold until every predicted duty has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [7:0] dmin, logic [7:0] dmax, logic [7:0] tlow,
                                 logic [7:0] thigh, logic [7:0] toff, logic [7:0] plow,
                                 logic [7:0] phigh, logic [7:0] poff);
        logic [CFG_DATA_W-1:0] regs [8];
        regs[CFG_DUTY_MIN]   = dmin;
        regs[CFG_DUTY_MAX]   = dmax;
        regs[CFG_TEMP_LOW]   = tlow;
        regs[CFG_TEMP_HIGH]  = thigh;
        regs[CFG_TEMP_OFF]   = toff;
        regs[CFG_POWER_LOW]  = plow;
        regs[CFG_POWER_HIGH] = phigh;
        regs[CFG_POWER_OFF]  = poff;
        for (int i = 0; i < 8; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= CFG_IDX_W'(i);
            i_cfg_wdata <= regs[i];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cfg_temp_low   = int'($signed(tlow));
        cfg_temp_high  = int'($signed(thigh));
        cfg_temp_off   = int'($signed(toff));
        cfg_power_low  = int'(plow);
        cfg_power_high = int'(phigh);
        cfg_power_off  = int'(poff);
    endtask

    // Random requests aimed mostly at the temperature, current and power breakpoints.
    task automatic random_requests(int count);
        logic [ADC_W-1:0] temp, cur, volt;
        int deg, watts, lo, hi;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1: temp = 16'($urandom);
                default: begin
                    case ($urandom_range(0, 2))
                        0:       deg = cfg_temp_off;
                        1:       deg = cfg_temp_low;
                        default: deg = cfg_temp_high;
                    endcase
                    deg = deg + int'($urandom_range(0, 6)) - 3;
                    if (deg < -128) deg = -128;
                    if (deg > 127) deg = 127;
                    temp = {8'(deg), 8'($urandom)};
                end
            endcase
            lo = ((cfg_power_off < cfg_power_low) ? cfg_power_off : cfg_power_low) - 2;
            hi = cfg_power_high + 2;
            if (lo < 0) lo = 0;
            if (hi > 255) hi = 255;
            watts = $urandom_range(lo, hi);
            case ($urandom_range(0, 3))
                0: begin
                    cur  = {8'd1, 8'($urandom)};
                    volt = {8'(watts), 8'($urandom)};
                end
                1: begin
                    cur  = {8'(watts), 8'($urandom)};
                    volt = {8'd1, 8'($urandom)};
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       cur = 16'($urandom);
                        1:       cur = 16'($urandom_range(1490, 1610));
                        default: cur = 16'($urandom_range(0, 1499));
                    endcase
                    volt = 16'($urandom);
                end
            endcase
            send_request(temp, cur, volt);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: temperature ends and breakpoints, current limits, power bands.
        send_request(16'h8000, 16'd0, 16'd0);
        send_request(16'h7FFF, 16'd0, 16'd0);
        send_request(16'h2D00, 16'd0, 16'd0);
        send_request(16'h2B80, 16'd0, 16'd0);
        send_request(16'h3BFF, 16'd0, 16'd0);
        send_request(16'h3C00, 16'd0, 16'd0);
        send_request(16'h2800, 16'd0, 16'd0);
        send_request(16'h27FF, 16'd0, 16'd0);
        send_request(16'hFFFF, 16'd0, 16'd0);
        send_request(16'h0000, 16'd1499, 16'd0);
        send_request(16'h0000, 16'd1500, 16'd0);
        send_request(16'h0000, 16'd1599, 16'd0);
        send_request(16'h0000, 16'd1600, 16'd0);
        send_request(16'h0000, 16'hFFFF, 16'd0);
        send_request(16'h0000, 16'h01FF, 16'h54FF);
        send_request(16'h0000, 16'h0100, 16'h5500);
        send_request(16'h0000, 16'h0180, 16'h6300);
        send_request(16'h0000, 16'h0100, 16'h6400);
        send_request(16'h0000, 16'h0100, 16'hB1AA);
        send_request(16'h0000, 16'h0155, 16'hFE00);
        send_request(16'h0000, 16'h0100, 16'hFFFF);
        send_request(16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(16'h2B00, 16'd1550, 16'd0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: apply_setting(8'd0, 8'd255, 8'h80, 8'h7F, 8'h80, 8'd0, 8'd255, 8'd0);
                1: apply_setting(8'd1, 8'd200, 8'd20, 8'd30, 8'd10, 8'd50, 8'd150, 8'd40);
                2: apply_setting(8'd0, 8'd8, 8'd0, 8'd16, 8'hFB, 8'd10, 8'd40, 8'd5);
                3: apply_setting(8'd200, 8'd50, 8'd45, 8'd60, 8'd40, 8'd100, 8'd255, 8'd85);
                4: apply_setting(8'd10, 8'd90, 8'd60, 8'd45, 8'd50, 8'd200, 8'd100, 8'd150);
                5: apply_setting(8'd255, 8'd255, 8'h7F, 8'h7F, 8'h7F, 8'd255, 8'd255, 8'd255);
                6: apply_setting(8'd0, 8'd0, 8'h80, 8'h80, 8'h80, 8'd0, 8'd0, 8'd0);
                7: apply_setting(RST_DUTY_MIN, RST_DUTY_MAX, RST_TEMP_LOW, RST_TEMP_HIGH,
                                 RST_TEMP_OFF, RST_POWER_LOW, RST_POWER_HIGH, RST_POWER_OFF);
                default: apply_setting(8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom), 8'($urandom),
                                       8'($urandom), 8'($urandom));
            endcase
            random_requests(ITEMS_PER_PHASE);
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
design/fdt_pkg.sv
design/fdt_mul.sv
design/fdt_div.sv
design/fan_duty_from_temp_current_power.sv
design/fdt_chk.sv
tb/sv/fan_duty_checker.sv
tb/sv/fan_duty_from_temp_current_power_test.sv
